[design/i128alu_pkg.sv]
// Shared types and constants for the 128-bit signed ALU.
package i128alu_pkg;
   localparam int WordBits = 128;
   localparam int CntBits  = $clog2(WordBits + 1);

   localparam logic [3:0] OpAdd = 4'd0;
   localparam logic [3:0] OpSub = 4'd1;
   localparam logic [3:0] OpMul = 4'd2;
   localparam logic [3:0] OpDiv = 4'd3;
   localparam logic [3:0] OpAnd = 4'd4;
   localparam logic [3:0] OpOr  = 4'd5;
   localparam logic [3:0] OpXor = 4'd6;
   localparam logic [3:0] OpNot = 4'd7;
   localparam logic [3:0] OpShl = 4'd8;
   localparam logic [3:0] OpSar = 4'd9;
   localparam logic [3:0] OpRol = 4'd10;
   localparam logic [3:0] OpRor = 4'd11;

   typedef logic [WordBits-1:0] word_type;

   // start and completion handshake between the top level and the iterative unit
   typedef struct packed {
      logic start;
      logic is_div;
   } seq_ctl_type;

   typedef struct packed {
      logic done;
   } seq_sts_type;
endpackage

[design/i128alu_iter.sv]
// Shared shift-add / shift-subtract unit for multiply and divide, one bit a cycle.
module i128alu_iter import i128alu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  seq_ctl_type ctl,
   input  word_type    op_a,
   input  word_type    op_b,
   output seq_sts_type sts,
   output word_type    prod,
   output word_type    quot
);
   logic                busy_ff, busy_in;
   logic                div_ff, div_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   word_type            acc_ff, acc_in;   // product accumulator or remainder
   word_type            q_ff, q_in;       // multiplier bits or dividend/quotient
   word_type            m_ff, m_in;       // shifted multiplicand or divisor
   logic [WordBits:0]   rem_sh;
   logic [WordBits:0]   diff;

   // load the operands on start, else one step of the shared adder
   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      q_in    = q_ff;
      m_in    = m_ff;
      rem_sh  = {acc_ff, q_ff[WordBits-1]};
      diff    = rem_sh - {1'b0, m_ff};
      if (ctl.start) begin
         busy_in = 1'b1;
         div_in  = ctl.is_div;
         cnt_in  = CntBits'(WordBits);
         acc_in  = '0;
         q_in    = ctl.is_div ? op_a : op_b;
         m_in    = ctl.is_div ? op_b : op_a;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) busy_in = 1'b0;
         if (div_ff) begin
            if (!diff[WordBits]) begin
               acc_in = diff[WordBits-1:0];
               q_in   = {q_ff[WordBits-2:0], 1'b1};
            end else begin
               acc_in = rem_sh[WordBits-1:0];
               q_in   = {q_ff[WordBits-2:0], 1'b0};
            end
         end else begin
            if (q_ff[0]) acc_in = acc_ff + m_ff;
            q_in = q_ff >> 1;
            m_in = m_ff << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      acc_ff <= acc_in;
      q_ff   <= q_in;
      m_ff   <= m_in;
   end

   assign sts.done = busy_ff && (cnt_ff == CntBits'(1));
   assign prod     = acc_in;
   assign quot     = q_in;
endmodule

[design/int128_signed_alu.sv]
// Top level of the 128-bit signed ALU: stream ports, sequencer, single-cycle ops.
// Add, sub, logic, shift and rotate results are registered at the accept edge and are
// offered in the next cycle. Multiply and divide with a nonzero divisor take
// 128 iterations of the shared shift-add/subtract unit, one sign fix, then the result.
// One transaction at a time; the next accept comes only after the result is taken.
// Synchronous active-high reset empties the block; payload registers are not reset.
module int128_signed_alu import i128alu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[3:0], a_high[67:4], a_low[131:68], b_high[195:132], b_low[259:196],
   // shift_amount[267:260], zero fill to 272
   input  logic [271:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_high[63:0], result_low[127:64], divide_by_zero[128], zero fill to 136
   output logic [135:0] rsp_tdata
);
   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StRun  = 2'd1;
   localparam logic [1:0] StFix  = 2'd2;
   localparam logic [1:0] StOut  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  op_ff;
   logic        neg_ff;
   word_type    res_ff, res_in;
   logic        dz_ff, dz_in;
   seq_ctl_type ctl;
   seq_sts_type sts;
   word_type    prod, quot, raw_ff;

   logic [3:0]  op;
   word_type    a, b, abs_a, abs_b, fast;
   logic [7:0]  sh;
   logic        accept;

   assign op  = req_tdata[3:0];
   assign a   = {req_tdata[67:4], req_tdata[131:68]};
   assign b   = {req_tdata[195:132], req_tdata[259:196]};
   assign sh  = req_tdata[267:260];
   assign abs_a = a[WordBits-1] ? -a : a;
   assign abs_b = b[WordBits-1] ? -b : b;
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == StIdle);

   // single-cycle operations
   always_comb begin
      case (op)
         OpAdd:   fast = a + b;
         OpSub:   fast = a - b;
         OpAnd:   fast = a & b;
         OpOr:    fast = a | b;
         OpXor:   fast = a ^ b;
         OpNot:   fast = ~a;
         OpShl:   fast = (sh >= 8'(WordBits)) ? '0 : (a << sh);
         OpSar:   fast = (sh >= 8'(WordBits)) ? {WordBits{a[WordBits-1]}}
                                             : word_type'($signed(a) >>> sh);
         OpRol:   fast = {a[WordBits-2:0], a[WordBits-1]};
         OpRor:   fast = {a[0], a[WordBits-1:1]};
         default: fast = '0;
      endcase
   end

   // launch the iterative unit for mul and div with a nonzero divisor
   always_comb begin
      ctl.start  = accept && (op == OpMul || (op == OpDiv && b != '0));
      ctl.is_div = (op == OpDiv);
   end

   i128alu_iter u_iter (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .op_a  (op == OpDiv ? abs_a : a),
      .op_b  (op == OpDiv ? abs_b : b),
      .sts   (sts),
      .prod  (prod),
      .quot  (quot)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      dz_in    = dz_ff;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               res_in = fast;
               dz_in  = (op == OpDiv) && (b == '0);
               if (ctl.start) state_in = StRun;
               else if (op == OpDiv) begin
                  res_in = '0;
                  state_in = StOut;
               end else state_in = StOut;
            end
         end
         StRun: begin
            if (sts.done) state_in = StFix;
         end
         StFix: begin
            res_in   = (op_ff == OpDiv && neg_ff) ? -raw_ff : raw_ff;
            state_in = StOut;
         end
         StOut: begin
            if (rsp_tready) state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= StIdle;
      else state_ff <= state_in;
      res_ff <= res_in;
      dz_ff  <= dz_in;
      if (accept) begin
         op_ff  <= op;
         neg_ff <= a[WordBits-1] ^ b[WordBits-1];
      end
      if (sts.done) raw_ff <= (op_ff == OpDiv) ? quot : prod;
   end

   assign rsp_tvalid = (state_ff == StOut);
   assign rsp_tdata  = {7'd0, dz_ff, res_ff[63:0], res_ff[127:64]};
endmodule

[design/i128alu_checker.sv]
// Port-level checker for the 128-bit signed ALU, bound to the top level.
module i128alu_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata
);
   // never ready for a new transaction while a result is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept while result pending");

   // an accepted transaction closes the input side next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("ready after accept");

   // divide-by-zero result is zero
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[128]) |-> (rsp_tdata[127:0] == '0))
      else $error("nonzero result on divide by zero");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed while stalled");
endmodule

bind int128_signed_alu i128alu_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/sv/tb.sv]
// Testbench for the 128-bit signed ALU: stream stimulus, scoreboard against a local ALU model.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import i128alu_pkg::*;

   typedef struct {
      logic [63:0] res_hi;
      logic [63:0] res_lo;
      logic        div_zero;
   } alu_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [271:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;

   alu_result_type expected_results[$];
   int unsigned    mismatch_count;
   int unsigned    cycle_count;
   int unsigned    hold_off_cycles;
   bit             idle_sender;

   localparam int unsigned CycleLimit = 2_000_000;

   int128_signed_alu u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock: 4 ns period
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // gap length: mostly short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // compute the ALU result in plain 128-bit arithmetic
   function automatic alu_result_type alu_predict(logic [3:0] op, word_type a, word_type b,
                                                  logic [7:0] sh);
      alu_result_type r;
      word_type       w;
      word_type       mag_a;
      word_type       mag_b;
      w = '0;
      r.div_zero = 1'b0;
      mag_a = a[WordBits-1] ? -a : a;
      mag_b = b[WordBits-1] ? -b : b;
      case (op)
         OpAdd: w = a + b;
         OpSub: w = a - b;
         OpMul: w = a * b;
         OpDiv: begin
            if (b == '0) begin
               r.div_zero = 1'b1;
            end else begin
               w = mag_a / mag_b;
               if (a[WordBits-1] != b[WordBits-1]) w = -w;
            end
         end
         OpAnd: w = a & b;
         OpOr:  w = a | b;
         OpXor: w = a ^ b;
         OpNot: w = ~a;
         OpShl: w = (sh >= WordBits) ? '0 : a << sh;
         OpSar: w = (sh >= WordBits) ? {WordBits{a[WordBits-1]}} : word_type'($signed(a) >>> sh);
         OpRol: w = {a[WordBits-2:0], a[WordBits-1]};
         OpRor: w = {a[0], a[WordBits-1:1]};
         default: w = '0;
      endcase
      r.res_hi = w[127:64];
      r.res_lo = w[63:0];
      return r;
   endfunction

   // offer one transaction, queue its expected result once accepted
   task automatic send_op(logic [3:0] op, word_type a, word_type b, logic [7:0] sh);
      int unsigned gap;
      gap = idle_sender ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, sh, b[63:0], b[127:64], a[63:0], a[127:64], op};
      do @(posedge clock); while (!req_tready);
      expected_results.insert(expected_results.size(), alu_predict(op, a, b, sh));
   endtask

   function automatic word_type rand_word();
      word_type w;
      int unsigned kind;
      w = {$urandom, $urandom, $urandom, $urandom};
      kind = $urandom_range(0, 9);
      if (kind == 0) w = '0;
      else if (kind == 1) w = '1;
      else if (kind == 2) w = {1'b1, 127'b0};
      else if (kind == 3) w = word_type'($urandom_range(0, 7));
      else if (kind == 4) w = -word_type'($urandom_range(1, 7));
      else if (kind == 5) w = w >> $urandom_range(0, 127);
      else if (kind == 6) w = -(w >> $urandom_range(0, 127));
      return w;
   endfunction

   task automatic test_directed();
      word_type min_neg;
      min_neg = {1'b1, 127'b0};
      send_op(OpAdd, '1, word_type'(1), 8'd0);
      send_op(OpAdd, min_neg - 1, word_type'(1), 8'd0);
      send_op(OpSub, min_neg, word_type'(1), 8'd0);
      send_op(OpMul, '1, '1, 8'd0);
      send_op(OpMul, {64'h1, 64'h0}, {64'h1, 64'h0}, 8'd0);
      send_op(OpDiv, word_type'(100), '0, 8'd0);
      send_op(OpDiv, '0, word_type'(7), 8'd0);
      send_op(OpDiv, min_neg, '1, 8'd0);
      send_op(OpDiv, -word_type'(7), word_type'(2), 8'd0);
      send_op(OpDiv, word_type'(7), -word_type'(2), 8'd0);
      send_op(OpAnd, '1, {2{64'h5555_5555_5555_5555}}, 8'd0);
      send_op(OpOr, {2{64'hAAAA_AAAA_AAAA_AAAA}}, {2{64'h5555_5555_5555_5555}}, 8'd0);
      send_op(OpXor, '1, '1, 8'd0);
      send_op(OpNot, '0, '1, 8'hFF);
      send_op(OpShl, '1, '0, 8'd127);
      send_op(OpShl, '1, '0, 8'd128);
      send_op(OpShl, '1, '0, 8'd255);
      send_op(OpSar, min_neg, '0, 8'd64);
      send_op(OpSar, min_neg, '0, 8'd200);
      send_op(OpSar, ~min_neg, '0, 8'd128);
      send_op(OpRol, min_neg, '0, 8'd0);
      send_op(OpRor, word_type'(1), '0, 8'd0);
      send_op(4'd12, '1, '1, 8'd5);
      send_op(4'd15, '1, '1, 8'd5);
   endtask

   task automatic test_random(int unsigned count);
      logic [3:0] op;
      for (int unsigned i = 0; i < count; i++) begin
         op = 4'($urandom_range(0, 15));
         if (op > OpRor && $urandom_range(0, 3) != 0) op = 4'($urandom_range(0, 11));
         send_op(op, rand_word(), rand_word(), 8'($urandom_range(0, 255)));
      end
   endtask

   // long receiver hold-off while the sender keeps offering
   task automatic test_backpressure();
      hold_off_cycles = 400;
      test_random(6);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   // receiver: random stalls, long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles != 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 9) < 7);
      end
   end

   // check each accepted result against the oldest expectation
   always @(posedge clock) begin
      alu_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_tdata[63:0] !== exp_r.res_hi || rsp_tdata[127:64] !== exp_r.res_lo ||
                rsp_tdata[128] !== exp_r.div_zero) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp hi %h lo %h dz %b, got hi %h lo %h dz %b",
                           exp_r.res_hi, exp_r.res_lo, exp_r.div_zero,
                           rsp_tdata[63:0], rsp_tdata[127:64], rsp_tdata[128]);
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      mismatch_count  = 0;
      cycle_count     = 0;
      hold_off_cycles = 0;
      idle_sender     = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      idle_sender = 1'b1;
      test_random(450);
      idle_sender = 1'b0;
      test_random(200);
      idle_sender = 1'b1;
      test_random(270);
      drain();
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
